@@ rtl/core/point_table_nearest_query_assert.svh @@
// Assertion macros shared by the point table RTL.
`ifndef POINT_TABLE_NEAREST_QUERY_ASSERT_SVH
`define POINT_TABLE_NEAREST_QUERY_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define PTNQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PTNQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ptnq_pkg.sv @@
// Package: types and constants of the point table with nearest-point query.
`default_nettype none

package ptnq_pkg;

  localparam int unsigned COORD_BITS    = 16;
  localparam int unsigned HANDLE_W      = 6;
  localparam int unsigned ORDER_W       = 16;
  localparam int unsigned MAX_NODES_DEF = 64;
  // squared difference of two COORD_BITS values fits in 2*COORD_BITS+1 bits
  localparam int unsigned SQ_W          = 2 * COORD_BITS + 1;
  localparam int unsigned DIST_W        = SQ_W + 2;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_NEAR   = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_BAD_HANDLE = 2'd2;
  localparam logic [1:0] ST_EMPTY      = 2'd3;

  typedef struct packed {
    logic [1:0]                   cmd;
    logic [HANDLE_W-1:0]          handle_in;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle_out;
    logic [1:0]          status;
  } out_item_t;

  // one table slot as held in memory
  typedef struct packed {
    logic                         vld;
    logic [ORDER_W-1:0]           order;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } entry_t;

  // control that travels with a slot down the distance pipeline
  typedef struct packed {
    logic               live;  // a scan read is in flight in this stage
    logic               hit;   // the slot read is occupied
    logic [ORDER_W-1:0] age;
  } scan_tag_t;

endpackage

`default_nettype wire

@@ rtl/core/ptnq_dist.sv @@
// Three-stage squared-distance pipeline: differences, squares, sum.
`default_nettype none

module ptnq_dist #(
  parameter int unsigned IDX_W = 6
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire ptnq_pkg::scan_tag_t                     tag_i,
  input  wire logic [IDX_W-1:0]                        idx_i,
  input  wire logic signed [ptnq_pkg::COORD_BITS-1:0]  px_i,
  input  wire logic signed [ptnq_pkg::COORD_BITS-1:0]  py_i,
  input  wire logic signed [ptnq_pkg::COORD_BITS-1:0]  pz_i,
  input  wire logic signed [ptnq_pkg::COORD_BITS-1:0]  qx_i,
  input  wire logic signed [ptnq_pkg::COORD_BITS-1:0]  qy_i,
  input  wire logic signed [ptnq_pkg::COORD_BITS-1:0]  qz_i,
  output      ptnq_pkg::scan_tag_t                     tag_o,
  output      logic [IDX_W-1:0]                        idx_o,
  output      logic [ptnq_pkg::DIST_W-1:0]             dist_o,
  output      logic                                    busy_o
);

  localparam int unsigned CB    = ptnq_pkg::COORD_BITS;
  localparam int unsigned SQ_W  = ptnq_pkg::SQ_W;
  localparam int unsigned DW    = ptnq_pkg::DIST_W;

  ptnq_pkg::scan_tag_t tag_a_q, tag_b_q, tag_c_q;
  logic [IDX_W-1:0]    idx_a_q, idx_b_q, idx_c_q;
  logic signed [CB:0]  dx_q, dy_q, dz_q;
  logic signed [CB:0]  dx_d, dy_d, dz_d;
  logic signed [2*CB+1:0] px2, py2, pz2;
  logic [SQ_W-1:0]     sqx_q, sqy_q, sqz_q;
  logic [DW-1:0]       dist_d, dist_q;

  // one extra bit keeps the difference exact
  assign dx_d = {qx_i[CB-1], qx_i} - {px_i[CB-1], px_i};
  assign dy_d = {qy_i[CB-1], qy_i} - {py_i[CB-1], py_i};
  assign dz_d = {qz_i[CB-1], qz_i} - {pz_i[CB-1], pz_i};

  assign px2 = dx_q * dx_q;
  assign py2 = dy_q * dy_q;
  assign pz2 = dz_q * dz_q;

  assign dist_d = {2'b00, sqx_q} + {2'b00, sqy_q} + {2'b00, sqz_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
      tag_c_q <= '0;
    end else begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
      tag_c_q <= tag_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_a_q <= idx_i;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    dz_q    <= dz_d;
    idx_b_q <= idx_a_q;
    sqx_q   <= px2[SQ_W-1:0];
    sqy_q   <= py2[SQ_W-1:0];
    sqz_q   <= pz2[SQ_W-1:0];
    idx_c_q <= idx_b_q;
    dist_q  <= dist_d;
  end

  assign tag_o  = tag_c_q;
  assign idx_o  = idx_c_q;
  assign dist_o = dist_q;
  assign busy_o = tag_a_q.live | tag_b_q.live | tag_c_q.live;

`include "point_table_nearest_query_assert.svh"

  `PTNQ_ASSERT_IMP(a_dist_latency, tag_o.live, $past(tag_i.live, 3),
                   "distance result without a scan read three cycles earlier")

endmodule

`default_nettype wire

@@ rtl/core/point_table_nearest_query.sv @@
// Insert: first-free-slot scan. Nearest: one slot read per cycle from the single
// table memory, then a 3-stage distance pipeline and a compare stage.
// One item is in work at a time; the result register frees the input while it waits.
// After reset a clearing sweep marks every slot free; no input transfer is taken during it.
`default_nettype none

module point_table_nearest_query #(
  parameter int unsigned MAX_NODES = ptnq_pkg::MAX_NODES_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire ptnq_pkg::in_item_t  in_item_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      ptnq_pkg::out_item_t out_item_o
);

  localparam int unsigned IDX_W = $clog2(MAX_NODES);
  localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);
  localparam int unsigned HW    = ptnq_pkg::HANDLE_W;
  localparam int unsigned EXT_W = IDX_W + HW;
  localparam int unsigned OW    = ptnq_pkg::ORDER_W;
  localparam int unsigned DW    = ptnq_pkg::DIST_W;

  localparam logic [CNT_W-1:0] N_CNT    = CNT_W'(MAX_NODES);
  localparam logic [CNT_W-1:0] N_LAST   = CNT_W'(MAX_NODES - 1);
  localparam logic [EXT_W-1:0] N_EXT    = EXT_W'(MAX_NODES);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_INS   = 3'd2;
  localparam logic [2:0] S_REM   = 3'd3;
  localparam logic [2:0] S_NEAR  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  function automatic logic [HW-1:0] to_handle(input logic [IDX_W-1:0] idx);
    logic [EXT_W-1:0] ext;
    ext = {{HW{1'b0}}, idx};
    return ext[HW-1:0];
  endfunction

  logic [2:0]          state_q, state_d;
  logic [CNT_W-1:0]    scan_q, scan_d;
  ptnq_pkg::in_item_t  req_q;
  logic                hin_ok_q;
  logic [IDX_W-1:0]    hin_idx_q;
  logic [EXT_W-1:0]    hin_ext;
  logic                hin_ok;
  logic [IDX_W-1:0]    hin_idx;
  logic                in_xfer;

  // table memory
  ptnq_pkg::entry_t    mem_q [MAX_NODES];
  ptnq_pkg::entry_t    rd_data_q;
  ptnq_pkg::entry_t    mem_wdata;
  logic [IDX_W-1:0]    mem_raddr, mem_waddr;
  logic                mem_we;
  logic                issue;
  logic                rd_vld_q;
  logic [IDX_W-1:0]    rd_idx_q;

  logic [OW-1:0]       next_order_q, next_order_d;

  // scan bookkeeping for nearest
  ptnq_pkg::scan_tag_t scan_tag, dist_tag;
  logic [IDX_W-1:0]    dist_idx;
  logic [DW-1:0]       near_dist;
  logic                dist_busy;
  logic                best_found_q;
  logic [DW-1:0]       best_dist_q;
  logic [OW-1:0]       best_age_q;
  logic [IDX_W-1:0]    best_idx_q;
  logic                best_upd;

  // pend_q holds the finished reply until the output register is free
  ptnq_pkg::out_item_t res_q, pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  logic                out_load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = res_q;

  assign hin_ext = {{IDX_W{1'b0}}, in_item_i.handle_in};
  assign hin_ok  = (hin_ext < N_EXT);
  assign hin_idx = hin_ext[IDX_W-1:0];

  assign scan_tag.live = rd_vld_q & (state_q == S_NEAR);
  assign scan_tag.hit  = rd_vld_q & (state_q == S_NEAR) & rd_data_q.vld;
  assign scan_tag.age  = next_order_q - rd_data_q.order;

  ptnq_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (scan_tag),
    .idx_i  (rd_idx_q),
    .px_i   (rd_data_q.x),
    .py_i   (rd_data_q.y),
    .pz_i   (rd_data_q.z),
    .qx_i   (req_q.coord_x),
    .qy_i   (req_q.coord_y),
    .qz_i   (req_q.coord_z),
    .tag_o  (dist_tag),
    .idx_o  (dist_idx),
    .dist_o (near_dist),
    .busy_o (dist_busy)
  );

  // strict compare over ascending slots: on full tie the lower slot stays
  assign best_upd = dist_tag.hit & (!best_found_q || (near_dist < best_dist_q) ||
                    ((near_dist == best_dist_q) && (dist_tag.age > best_age_q)));

  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    mem_raddr    = scan_q[IDX_W-1:0];
    mem_we       = 1'b0;
    mem_waddr    = rd_idx_q;
    mem_wdata    = rd_data_q;
    issue        = 1'b0;
    next_order_d = next_order_q;
    pend_d       = pend_q;
    out_load     = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we        = 1'b1;
        mem_waddr     = scan_q[IDX_W-1:0];
        mem_wdata     = '0;
        scan_d        = scan_q + 1'b1;
        if (scan_q == N_LAST) begin
          scan_d  = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_raddr = hin_idx;
        if (in_xfer) begin
          scan_d = '0;
          unique case (in_item_i.cmd)
            ptnq_pkg::CMD_INSERT: state_d = S_INS;
            ptnq_pkg::CMD_REMOVE: state_d = S_REM;
            ptnq_pkg::CMD_NEAR:   state_d = S_NEAR;
            default: begin
              pend_d.handle_out = '0;
              pend_d.status     = ptnq_pkg::ST_OK;
              state_d           = S_RESP;
            end
          endcase
        end
      end
      S_INS: begin
        issue = (scan_q != N_CNT);
        if (issue) scan_d = scan_q + 1'b1;
        priority if (rd_vld_q && !rd_data_q.vld) begin
          mem_we            = 1'b1;
          mem_waddr         = rd_idx_q;
          mem_wdata.vld     = 1'b1;
          mem_wdata.order   = next_order_q;
          mem_wdata.x       = req_q.coord_x;
          mem_wdata.y       = req_q.coord_y;
          mem_wdata.z       = req_q.coord_z;
          next_order_d      = next_order_q + 1'b1;
          pend_d.handle_out = to_handle(rd_idx_q);
          pend_d.status     = ptnq_pkg::ST_OK;
          state_d           = S_RESP;
        end else if (!issue && !rd_vld_q) begin
          pend_d.handle_out = '0;
          pend_d.status     = ptnq_pkg::ST_FULL;
          state_d           = S_RESP;
        end
      end
      S_REM: begin
        // rd_data_q holds the slot read at the input transfer
        pend_d.handle_out = req_q.handle_in;
        if (hin_ok_q && rd_data_q.vld) begin
          mem_we        = 1'b1;
          mem_waddr     = hin_idx_q;
          mem_wdata.vld = 1'b0;
          pend_d.status = ptnq_pkg::ST_OK;
        end else begin
          pend_d.status = ptnq_pkg::ST_BAD_HANDLE;
        end
        state_d = S_RESP;
      end
      S_NEAR: begin
        issue = (scan_q != N_CNT);
        if (issue) scan_d = scan_q + 1'b1;
        if (!issue && !rd_vld_q && !dist_busy) begin
          if (best_found_q) begin
            pend_d.handle_out = to_handle(best_idx_q);
            pend_d.status     = ptnq_pkg::ST_OK;
          end else begin
            pend_d.handle_out = '0;
            pend_d.status     = ptnq_pkg::ST_EMPTY;
          end
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = (out_valid_q & ~out_ready_i) | out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      scan_q       <= '0;
      rd_vld_q     <= 1'b0;
      next_order_q <= '0;
      best_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      scan_q       <= scan_d;
      rd_vld_q     <= issue;
      next_order_q <= next_order_d;
      out_valid_q  <= out_valid_d;
      if (in_xfer) begin
        best_found_q <= 1'b0;
      end else if (best_upd) begin
        best_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_q[IDX_W-1:0];
    pend_q   <= pend_d;
    if (out_load) res_q <= pend_q;
    if (in_xfer) begin
      req_q     <= in_item_i;
      hin_ok_q  <= hin_ok;
      hin_idx_q <= hin_idx;
    end
    if (best_upd) begin
      best_dist_q <= near_dist;
      best_age_q  <= dist_tag.age;
      best_idx_q  <= dist_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rd_data_q <= mem_q[mem_raddr];
  end

`include "point_table_nearest_query_assert.svh"

  `PTNQ_ASSERT_IMP(a_near_no_write, state_q == S_NEAR, !mem_we,
                   "table written during a nearest scan")
  `PTNQ_ASSERT_NXT(a_order_step, (state_q == S_INS) && mem_we,
                   next_order_q == $past(next_order_q) + 16'd1,
                   "insertion order did not advance on insert")
  `PTNQ_ASSERT_IMP(a_remove_frees, (state_q == S_REM) && mem_we, !mem_wdata.vld,
                   "remove wrote an occupied slot")

endmodule

`default_nettype wire
